// ===== src/sil_pkg.sv =====
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and constants for the sorted insert list unit.
// ----------------------------------------------------------------------------
package sil_pkg;

    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int VALUE_W = 31;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam logic [1:0] ST_ELEMENT = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] item_value;
        logic [1:0]         status;
        logic               last;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic ins;
        logic pop;
        logic load_drop;
        logic load_empty;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic count_zero;
        logic count_one;
        logic out_free;
    } sts_t;

endpackage

// ===== src/sil_ctrl.sv =====
// ----------------------------------------------------------------------------
// sil_ctrl
// Request sequencing: inserts and status results issued in the accept cycle,
// and a drain sequence that pops one entry per cycle into a free output register.
// ----------------------------------------------------------------------------
module sil_ctrl
    import sil_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_op,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = sts.out_free;
                accept   = in_valid && sts.out_free;
                if (accept)
                begin
                    if (in_op == OP_INSERT)
                    begin
                        if (sts.full)
                            cmd.load_drop = 1'b1;
                        else
                            cmd.ins = 1'b1;
                    end
                    else
                    begin
                        if (sts.count_zero)
                            cmd.load_empty = 1'b1;
                        else
                            state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.pop = 1'b1;
                    if (sts.count_one)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> !in_ready)
        else $error("request taken during drain");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> !sts.count_zero)
        else $error("drain running on empty list");

endmodule

// ===== src/sil_datapath.sv =====
// ----------------------------------------------------------------------------
// sil_datapath
// Ordered register chain with parallel compare-and-shift insert, head pop
// for drain, entry count and the output register.
// ----------------------------------------------------------------------------
module sil_datapath
    import sil_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VALUE_W-1:0] in_value,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               out_ready,
    output logic               out_valid,
    output out_t               out_data
);

    logic [VALUE_W-1:0] entries_reg [DEPTH];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_t               out_data_reg;
    out_t               out_data_next;
    logic [DEPTH-1:0]   lt;
    logic               load;

    // lt is a prefix over held entries: insert lands at the first clear bit
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            lt[i] = (COUNT_W'(i) < count_reg) && (in_value > entries_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins)
        begin
            if (!lt[0])
                entries_reg[0] <= in_value;
            for (int i = 1; i < DEPTH; i++)
            begin
                if (!lt[i])
                begin
                    if (lt[i-1])
                        entries_reg[i] <= in_value;
                    else
                        entries_reg[i] <= entries_reg[i-1];
                end
            end
        end
        else if (cmd.pop)
        begin
            // advance the chain toward the head
            for (int i = 0; i < DEPTH - 1; i++)
                entries_reg[i] <= entries_reg[i+1];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + COUNT_W'(1);
        else if (cmd.pop)
            count_next = count_reg - COUNT_W'(1);
    end

    assign sts.full       = (count_reg == COUNT_W'(DEPTH));
    assign sts.count_zero = (count_reg == '0);
    assign sts.count_one  = (count_reg == COUNT_W'(1));
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign load = cmd.pop || cmd.load_drop || cmd.load_empty;

    always_comb
    begin
        out_data_next = out_data_reg;
        if (cmd.pop)
        begin
            out_data_next.item_value = entries_reg[0];
            out_data_next.status     = ST_ELEMENT;
            out_data_next.last       = (count_reg == COUNT_W'(1));
        end
        else if (cmd.load_drop)
        begin
            out_data_next.item_value = '0;
            out_data_next.status     = ST_DROPPED;
            out_data_next.last       = 1'b1;
        end
        else if (cmd.load_empty)
        begin
            out_data_next.item_value = '0;
            out_data_next.status     = ST_EMPTY;
            out_data_next.last       = 1'b1;
        end
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("entry count above depth");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> !sts.full)
        else $error("insert into full list");

    a_pop_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && sts.count_one) |=> sts.count_zero)
        else $error("list not empty after final pop");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> sts.out_free)
        else $error("output register overwritten");

endmodule

// ===== src/sorted_insert_list_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_insert_list_unit
// Bounded ascending list: ordered insert with drop-on-full, and a drain that empties it.
// ----------------------------------------------------------------------------
// Insert: list and count update at the end of the accept cycle; an insert
//   into a full list gives its dropped result from the output register in
//   the cycle after acceptance. Drain: pops the chain head into the output
//   register entry by entry (an empty list loads its empty result at once);
//   the first element passes the drain state, then the output register; no
//   request is taken until the final result is loaded; a held output stalls both.
// Reset clears the entry count and the output valid; entries are not cleared.
module sorted_insert_list_unit
    import sil_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    cmd_t cmd;
    sts_t sts;

    sil_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_data.op),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sil_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_value  (in_data.value),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
